// ===== sv/was_pkg.sv =====
// ----------------------------------------------------------------------------
// was_pkg
// Shared types and constants of the weighted action selector.
// ----------------------------------------------------------------------------
package was_pkg;

    localparam int NUM_STATES  = 16;
    localparam int MAX_ACTIONS = 8;

    localparam int ACT_W   = 16;
    localparam int PROB_W  = 17;
    localparam int SIDX_IN_W = 4;
    localparam int TOT_W   = PROB_W + 1;
    localparam int CNT_W   = $clog2(MAX_ACTIONS + 1);
    localparam int SLOT_W  = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int SIDX_W  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int ADDR_W  = SIDX_W + SLOT_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int ACC_W   = PROB_W + CNT_W;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = PROB_W + FRAC_W;
    localparam int DIV_CW  = $clog2(DVD_W + 1);

    localparam logic [PROB_W-1:0] ONE_FIXED = PROB_W'(65536);
    localparam logic [ACT_W-1:0]  INVALID_RESET = ACT_W'(65535);

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NODEC = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

endpackage

// ===== sv/was_if.sv =====
// ----------------------------------------------------------------------------
// was_if
// Request, response and configuration channels of the selector.
// ----------------------------------------------------------------------------
interface was_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [was_pkg::SIDX_IN_W-1:0] state_index;
    logic [was_pkg::ACT_W-1:0]     action_id;
    logic [was_pkg::PROB_W-1:0]    probability;
    logic [was_pkg::PROB_W-1:0]    roulette;
    modport source (output valid, mode, state_index, action_id, probability, roulette,
                    input ready);
    modport sink   (input valid, mode, state_index, action_id, probability, roulette,
                    output ready);
endinterface

interface was_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [was_pkg::ACT_W-1:0] chosen_action;
    logic [1:0]                status;
    modport source (output valid, chosen_action, status, input ready);
    modport sink   (input valid, chosen_action, status, output ready);
endinterface

interface was_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [was_pkg::ACT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/was_div.sv =====
// ----------------------------------------------------------------------------
// was_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module was_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [was_pkg::DVD_W-1:0]    i_dividend,
    input  logic [was_pkg::TOT_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [was_pkg::PROB_W-1:0]   o_quotient
);
    logic                         r_busy;
    logic                         r_done;
    logic [was_pkg::DIV_CW-1:0]   r_cnt;
    logic [was_pkg::TOT_W-1:0]    r_rem;
    logic [was_pkg::TOT_W-1:0]    r_div;
    logic [was_pkg::DVD_W-1:0]    r_dvd;
    logic [was_pkg::TOT_W:0]      trial;
    logic [was_pkg::TOT_W:0]      diff;
    logic                         ge;

    assign trial = {r_rem, r_dvd[was_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= was_pkg::DIV_CW'(was_pkg::DVD_W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_dvd  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? diff[was_pkg::TOT_W-1:0] : trial[was_pkg::TOT_W-1:0];
                r_dvd <= {r_dvd[was_pkg::DVD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == was_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd[was_pkg::PROB_W-1:0];
endmodule

// ===== sv/weighted_action_selector_core.sv =====
// ----------------------------------------------------------------------------
// weighted_action_selector_core
// Per-state roulette-wheel action tables with add, rescale and decide.
// ----------------------------------------------------------------------------
// One request at a time. An add that needs no rescale, a dropped add and a
// decide that fails its checks go from idle to the done state and on to the
// result register. A decide walks the entries through a read state and a
// check state per entry, as the read of the entry memory is registered. An
// add that pushes the total above 1.0 rescales each of the state's n entries,
// up to eight, with a serial divider. A new request is taken while a finished
// response still waits in the output register.
module weighted_action_selector_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    was_req_if.sink   i_req,
    was_rsp_if.source o_rsp,
    was_cfg_if.sink   i_cfg
);
    typedef enum logic [2:0] {
        S_IDLE, S_RS_RD, S_RS_LAT, S_RS_DIV, S_DEC_RD, S_DEC_CHK, S_DONE
    } t_state;

    t_state                            r_state;
    logic [was_pkg::ACT_W-1:0]         r_inv;
    logic [was_pkg::CNT_W-1:0]         r_cnt [was_pkg::NUM_STATES];
    logic [was_pkg::PROB_W-1:0]        r_tot [was_pkg::NUM_STATES];
    logic [was_pkg::ACT_W-1:0]         mem_act  [was_pkg::DEPTH];
    logic [was_pkg::PROB_W-1:0]        mem_prob [was_pkg::DEPTH];
    logic [was_pkg::ACT_W-1:0]         r_rd_act;
    logic [was_pkg::PROB_W-1:0]        r_rd_prob;
    logic [was_pkg::SIDX_W-1:0]        r_idx;
    logic [was_pkg::SLOT_W-1:0]        r_i;
    logic [was_pkg::CNT_W-1:0]         r_n;
    logic [was_pkg::TOT_W-1:0]         r_total;
    logic [was_pkg::PROB_W-1:0]        r_roul;
    logic [was_pkg::ACC_W-1:0]         r_acc;
    logic [was_pkg::ACT_W-1:0]         r_chosen;
    was_pkg::t_status                  r_stat;
    logic                              r_ovalid;
    logic [was_pkg::ACT_W-1:0]         r_ochosen;
    was_pkg::t_status                  r_ostat;

    logic                              req_acc;
    logic                              req_oor;
    logic [was_pkg::SIDX_W-1:0]        sidx;
    logic [was_pkg::CNT_W-1:0]         cur_cnt;
    logic [was_pkg::PROB_W-1:0]        cur_tot;
    logic [was_pkg::TOT_W-1:0]         sum;
    logic                              full;
    logic [was_pkg::PROB_W-1:0]        roul_c;
    logic                              we_act;
    logic                              we_prob;
    logic [was_pkg::ADDR_W-1:0]        wa;
    logic [was_pkg::PROB_W-1:0]        wprob;
    logic [was_pkg::ADDR_W-1:0]        ra;
    logic                              div_start;
    logic                              div_done;
    logic [was_pkg::PROB_W-1:0]        div_q;
    logic [was_pkg::ACC_W-1:0]         acc_n;
    logic                              last;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign req_oor     = 32'(i_req.state_index) >= was_pkg::NUM_STATES;
    assign sidx        = i_req.state_index[was_pkg::SIDX_W-1:0];
    assign cur_cnt     = r_cnt[sidx];
    assign cur_tot     = r_tot[sidx];
    assign sum         = {1'b0, cur_tot} + {1'b0, i_req.probability};
    assign full        = cur_cnt >= was_pkg::CNT_W'(was_pkg::MAX_ACTIONS);
    assign roul_c      = (i_req.roulette > was_pkg::ONE_FIXED) ? was_pkg::ONE_FIXED
                                                                : i_req.roulette;

    assign we_act  = req_acc && !i_req.mode && !req_oor && !full;
    assign we_prob = we_act || (r_state == S_RS_DIV && div_done);
    assign wa      = (r_state == S_IDLE) ? {sidx, cur_cnt[was_pkg::SLOT_W-1:0]}
                                         : {r_idx, r_i};
    assign wprob   = (r_state == S_IDLE) ? i_req.probability : div_q;
    assign ra      = {r_idx, r_i};

    assign div_start = (r_state == S_RS_LAT);
    assign acc_n     = r_acc + was_pkg::ACC_W'(r_rd_prob);
    assign last      = (was_pkg::CNT_W'(r_i) + 1'b1) == r_n;

    was_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rd_prob, was_pkg::FRAC_W'(0)}),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (we_act) begin
            mem_act[wa] <= i_req.action_id;
        end
        if (we_prob) begin
            mem_prob[wa] <= wprob;
        end
        r_rd_act  <= mem_act[ra];
        r_rd_prob <= mem_prob[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inv    <= was_pkg::INVALID_RESET;
            r_ovalid <= 1'b0;
            for (int k = 0; k < was_pkg::NUM_STATES; k++) begin
                r_cnt[k] <= '0;
                r_tot[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_inv <= i_cfg.data;
            end
            if (o_rsp.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_idx   <= sidx;
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_roul  <= roul_c;
                        r_n     <= cur_cnt;
                        r_state <= S_DONE;
                        if (!i_req.mode) begin
                            r_chosen <= '0;
                            if (req_oor || full) begin
                                r_stat <= was_pkg::STAT_FULL;
                            end else begin
                                r_stat       <= was_pkg::STAT_OK;
                                r_cnt[sidx]  <= cur_cnt + 1'b1;
                                r_n          <= cur_cnt + 1'b1;
                                r_total      <= sum;
                                if (sum > was_pkg::TOT_W'(was_pkg::ONE_FIXED)) begin
                                    r_tot[sidx] <= was_pkg::ONE_FIXED;
                                    r_state     <= S_RS_RD;
                                end else begin
                                    r_tot[sidx] <= sum[was_pkg::PROB_W-1:0];
                                end
                            end
                        end else begin
                            r_chosen <= r_inv;
                            r_stat   <= was_pkg::STAT_NODEC;
                            if (!req_oor && !(roul_c > cur_tot) && cur_cnt != '0) begin
                                r_state <= S_DEC_RD;
                            end
                        end
                    end
                end
                S_RS_RD:  r_state <= S_RS_LAT;
                S_RS_LAT: r_state <= S_RS_DIV;
                S_RS_DIV: begin
                    if (div_done) begin
                        if (last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RS_RD;
                        end
                    end
                end
                S_DEC_RD: r_state <= S_DEC_CHK;
                S_DEC_CHK: begin
                    r_acc <= acc_n;
                    if (acc_n >= was_pkg::ACC_W'(r_roul) || last) begin
                        r_chosen <= r_rd_act;
                        r_stat   <= was_pkg::STAT_OK;
                        r_state  <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DEC_RD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ochosen <= r_chosen;
                        r_ostat   <= r_stat;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.chosen_action = r_ochosen;
    assign o_rsp.status        = r_ostat;
endmodule
